>>> rtl/rbi_pkg.sv
// Shared types, constants and helper functions of the rigid body integrator.
package rbi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CMD_W = 3;
  localparam int SCL_W = 31;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [31:0] word_t;
  typedef logic [SCL_W-1:0] scl_t;

  localparam logic [CMD_W-1:0] CMD_FORCE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FORCE_PT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TORQUE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FRICTION = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_IX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_IY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_IZ   = 2'd3;

  localparam word_t QUAT_ONE = 32'sh4000_0000;

  typedef struct packed {
    logic [1:0] di;
    logic [1:0] hi;
    logic [1:0] qi;
    logic       neg;
  } qterm_t;

  function automatic word_t sat32(input logic signed [65:0] x);
    word_t r;
    if (x > 66'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (x < -66'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // Terms of the quaternion derivative: destination, rate axis, quaternion part, sign.
  function automatic qterm_t qterm(input logic [3:0] j);
    qterm_t t;
    case (j)
      4'd0:    t = '{di: 2'd0, hi: 2'd0, qi: 2'd1, neg: 1'b1};
      4'd1:    t = '{di: 2'd0, hi: 2'd1, qi: 2'd2, neg: 1'b1};
      4'd2:    t = '{di: 2'd0, hi: 2'd2, qi: 2'd3, neg: 1'b1};
      4'd3:    t = '{di: 2'd1, hi: 2'd0, qi: 2'd0, neg: 1'b0};
      4'd4:    t = '{di: 2'd1, hi: 2'd1, qi: 2'd3, neg: 1'b0};
      4'd5:    t = '{di: 2'd1, hi: 2'd2, qi: 2'd2, neg: 1'b1};
      4'd6:    t = '{di: 2'd2, hi: 2'd1, qi: 2'd0, neg: 1'b0};
      4'd7:    t = '{di: 2'd2, hi: 2'd2, qi: 2'd1, neg: 1'b0};
      4'd8:    t = '{di: 2'd2, hi: 2'd0, qi: 2'd3, neg: 1'b1};
      4'd9:    t = '{di: 2'd3, hi: 2'd2, qi: 2'd0, neg: 1'b0};
      4'd10:   t = '{di: 2'd3, hi: 2'd0, qi: 2'd2, neg: 1'b0};
      4'd11:   t = '{di: 2'd3, hi: 2'd1, qi: 2'd1, neg: 1'b1};
      default: t = '{di: 2'd0, hi: 2'd0, qi: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

>>> rtl/rbi_chan_if.sv
// Valid/ready channels of the rigid body integrator: command items in, pose items out.
interface rbi_in_if import rbi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  scl_t             time_step;
  word_t            vec_x;
  word_t            vec_y;
  word_t            vec_z;
  word_t            point_x;
  word_t            point_y;
  word_t            point_z;
  scl_t             friction_coeff;

  modport source (output valid, command, time_step, vec_x, vec_y, vec_z,
                  point_x, point_y, point_z, friction_coeff, input ready);
  modport sink (input valid, command, time_step, vec_x, vec_y, vec_z,
                point_x, point_y, point_z, friction_coeff, output ready);
endinterface

interface rbi_out_if import rbi_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t pos_x;
  word_t pos_y;
  word_t pos_z;
  word_t quat_w;
  word_t quat_x;
  word_t quat_y;
  word_t quat_z;

  modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                output ready);
endinterface

>>> rtl/rigid_body_integrator_unit.sv
// Rigid body integrator: body state, shared multiplier, divider and square-root sequencer.
//
// Use: in_ch carries one command item (force at centre, force at point, torque,
// friction, update); out_ch returns one item per command with the position and the
// orientation quaternion after it. cfg_we/cfg_index/cfg_data write the inverse mass
// and the three inverse inertia terms; write them only while the block is idle.
// Every command runs on one 32x32 multiplier, one restoring divider (one quotient
// bit a cycle) and one square-root unit (one result bit a cycle) under a sequencer.
// An update skips the quaternion rate step when the angular velocity is zero; the
// normalization always runs. The divider's 33 steps per quaternion part or velocity
// component dominate the friction and update commands. in_ch.ready is high only
// while the sequencer is idle; a finished item waits in the output register while the
// next command is taken, and the sequencer holds its result until out_ch is free.
// Reset (synchronous, rst_n low) clears position and velocities, sets the
// quaternion to identity and all four registers to one.
module rigid_body_integrator_unit import rbi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rbi_in_if.sink               in_ch,
  rbi_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  scl_t                 cfg_data
);

  localparam scl_t ONE_SCL = SCL_W'(1) << FRAC_BITS;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_VM1  = 5'd1;
  localparam logic [4:0] ST_VS1  = 5'd2;
  localparam logic [4:0] ST_VM2  = 5'd3;
  localparam logic [4:0] ST_VAC  = 5'd4;
  localparam logic [4:0] ST_ARM  = 5'd5;
  localparam logic [4:0] ST_CMUL = 5'd6;
  localparam logic [4:0] ST_CACC = 5'd7;
  localparam logic [4:0] ST_PMUL = 5'd8;
  localparam logic [4:0] ST_PACC = 5'd9;
  localparam logic [4:0] ST_HMUL = 5'd10;
  localparam logic [4:0] ST_HACC = 5'd11;
  localparam logic [4:0] ST_QMUL = 5'd12;
  localparam logic [4:0] ST_QACC = 5'd13;
  localparam logic [4:0] ST_QADD = 5'd14;
  localparam logic [4:0] ST_SMUL = 5'd15;
  localparam logic [4:0] ST_SACC = 5'd16;
  localparam logic [4:0] ST_SQRT = 5'd17;
  localparam logic [4:0] ST_DSET = 5'd18;
  localparam logic [4:0] ST_DRUN = 5'd19;
  localparam logic [4:0] ST_DWB  = 5'd20;
  localparam logic [4:0] ST_DONE = 5'd21;

  logic [4:0]       state_r;
  logic [3:0]       idx_r;
  logic [5:0]       cnt_r;
  logic             ang_r;
  logic [CMD_W-1:0] cmd_r;

  scl_t  inv_mass_r;
  scl_t  inv_in_r [3];
  word_t pos_r [3];
  word_t lv_r [3];
  word_t av_r [3];
  word_t q_r [4];

  scl_t  dt_r;
  scl_t  coeff_r;
  word_t vec_r [3];
  word_t pt_r [3];
  word_t tq_r [3];
  word_t arm_r [3];
  word_t h_r [3];
  word_t tmp_r;
  logic signed [65:0] cacc_r;
  logic signed [47:0] d_r [4];
  logic signed [65:0] prod_r;

  logic [63:0] s_r;
  logic [63:0] sq_r;
  logic [63:0] bit_r;
  logic [31:0] len_r;

  logic [31:0] rem_r;
  logic [32:0] low_r;
  logic [32:0] quo_r;
  logic [31:0] den_r;
  logic        neg_r;
  logic        ovf_r;

  logic  out_valid_r;
  word_t out_pos_r [3];
  word_t out_q_r [4];

  logic               in_acc;
  logic               out_load;
  logic [1:0]         i2;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  word_t              scaled;
  logic signed [65:0] fs1;
  qterm_t             qt;
  logic               fric;
  word_t              vsel;
  logic signed [63:0] dnum;
  logic [63:0]        dmag;
  logic [31:0]        dden;
  logic [32:0]        trial;
  logic               take;
  word_t              dres;
  logic [63:0]        sq_try;

  assign i2       = idx_r[1:0];
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign qt       = qterm(idx_r);
  assign scaled   = sat32(prod_r >>> FRAC_BITS);
  assign fs1      = prod_r >>> (FRAC_BITS + 1);
  assign fric     = (cmd_r == CMD_FRICTION);
  assign vsel     = ang_r ? av_r[i2] : lv_r[i2];
  assign dnum     = fric ? (64'(vsel) <<< FRAC_BITS) : (64'(q_r[i2]) <<< 29);
  assign dmag     = dnum[63] ? (~dnum + 64'd1) : dnum;
  assign dden     = fric ? ({1'b0, ONE_SCL} + {1'b0, coeff_r}) : len_r;
  assign trial    = {rem_r, low_r[32]};
  assign take     = (trial >= {1'b0, den_r});
  assign sq_try   = sq_r + bit_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_VM1: begin
        mul_a = 33'(ang_r ? tq_r[i2] : vec_r[i2]);
        mul_b = $signed({2'b00, dt_r});
      end
      ST_VM2: begin
        mul_a = 33'(tmp_r);
        mul_b = $signed({2'b00, (ang_r ? inv_in_r[i2] : inv_mass_r)});
      end
      ST_CMUL: begin
        case (idx_r)
          4'd0:    begin mul_a = 33'(arm_r[1]); mul_b = 33'(vec_r[2]); end
          4'd1:    begin mul_a = 33'(arm_r[2]); mul_b = 33'(vec_r[1]); end
          4'd2:    begin mul_a = 33'(arm_r[2]); mul_b = 33'(vec_r[0]); end
          4'd3:    begin mul_a = 33'(arm_r[0]); mul_b = 33'(vec_r[2]); end
          4'd4:    begin mul_a = 33'(arm_r[0]); mul_b = 33'(vec_r[1]); end
          default: begin mul_a = 33'(arm_r[1]); mul_b = 33'(vec_r[0]); end
        endcase
      end
      ST_PMUL: begin
        mul_a = 33'(lv_r[i2]);
        mul_b = $signed({2'b00, dt_r});
      end
      ST_HMUL: begin
        mul_a = 33'(av_r[i2]);
        mul_b = $signed({2'b00, dt_r});
      end
      ST_QMUL: begin
        mul_a = 33'(h_r[qt.hi]);
        mul_b = 33'(q_r[qt.qi]);
      end
      ST_SMUL: begin
        mul_a = 33'(q_r[i2]);
        mul_b = 33'(q_r[i2]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    if (neg_r) begin
      if (ovf_r || quo_r > 33'h0_8000_0000) dres = 32'sh8000_0000;
      else dres = -$signed(quo_r[31:0]);
    end else begin
      if (ovf_r || quo_r[32:31] != 2'b00) dres = 32'sh7FFF_FFFF;
      else dres = $signed(quo_r[31:0]);
    end
  end

  // Datapath operands and scratch values.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      dt_r     <= in_ch.time_step;
      coeff_r  <= in_ch.friction_coeff;
      vec_r[0] <= in_ch.vec_x;
      vec_r[1] <= in_ch.vec_y;
      vec_r[2] <= in_ch.vec_z;
      pt_r[0]  <= in_ch.point_x;
      pt_r[1]  <= in_ch.point_y;
      pt_r[2]  <= in_ch.point_z;
      tq_r[0]  <= in_ch.vec_x;
      tq_r[1]  <= in_ch.vec_y;
      tq_r[2]  <= in_ch.vec_z;
    end
    case (state_r)
      ST_VS1: tmp_r <= scaled;
      ST_ARM: begin
        for (int k = 0; k < 3; k++) arm_r[k] <= sat32(66'(pt_r[k]) - 66'(pos_r[k]));
      end
      ST_CACC: begin
        if (!idx_r[0]) cacc_r <= prod_r >>> FRAC_BITS;
        else tq_r[idx_r[2:1]] <= sat32(cacc_r - (prod_r >>> FRAC_BITS));
      end
      ST_HACC: h_r[i2] <= scaled;
      ST_PACC: begin
        for (int k = 0; k < 4; k++) d_r[k] <= '0;
      end
      ST_QACC: begin
        if (qt.neg) d_r[qt.di] <= d_r[qt.di] - 48'(fs1);
        else d_r[qt.di] <= d_r[qt.di] + 48'(fs1);
      end
      ST_QADD: s_r <= '0;
      ST_SACC: begin
        s_r <= s_r + {2'b00, prod_r[63:2]};
        if (i2 == 2'd3) begin
          sq_r  <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      ST_SQRT: begin
        if (bit_r != 64'd0) begin
          if (s_r >= sq_try) begin
            s_r  <= s_r - sq_try;
            sq_r <= (sq_r >> 1) + bit_r;
          end else begin
            sq_r <= sq_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          len_r <= sq_r[31:0];
        end
      end
      ST_DSET: begin
        neg_r <= dnum[63];
        ovf_r <= ({1'b0, dmag[63:33]} >= dden);
        rem_r <= {1'b0, dmag[63:33]};
        low_r <= dmag[32:0];
        den_r <= dden;
        quo_r <= '0;
      end
      ST_DRUN: begin
        rem_r <= take ? 32'(trial - {1'b0, den_r}) : trial[31:0];
        quo_r <= {quo_r[31:0], take};
        low_r <= {low_r[31:0], 1'b0};
      end
      default: begin
      end
    endcase
    if (out_load) begin
      for (int k = 0; k < 3; k++) out_pos_r[k] <= pos_r[k];
      for (int k = 0; k < 4; k++) out_q_r[k] <= q_r[k];
    end
  end

  // Sequencer and body state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      ang_r       <= 1'b0;
      cmd_r       <= CMD_FORCE;
      out_valid_r <= 1'b0;
      inv_mass_r  <= ONE_SCL;
      for (int k = 0; k < 3; k++) begin
        inv_in_r[k] <= ONE_SCL;
        pos_r[k]    <= '0;
        lv_r[k]     <= '0;
        av_r[k]     <= '0;
      end
      q_r[0] <= QUAT_ONE;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INV_MASS: inv_mass_r  <= cfg_data;
          CFG_INV_IX:   inv_in_r[0] <= cfg_data;
          CFG_INV_IY:   inv_in_r[1] <= cfg_data;
          CFG_INV_IZ:   inv_in_r[2] <= cfg_data;
          default:      inv_mass_r  <= inv_mass_r;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_ch.command;
            idx_r <= '0;
            ang_r <= (in_ch.command == CMD_TORQUE);
            case (in_ch.command)
              CMD_FORCE, CMD_FORCE_PT, CMD_TORQUE: state_r <= ST_VM1;
              CMD_FRICTION: state_r <= ST_DSET;
              CMD_UPDATE:   state_r <= ST_PMUL;
              default:      state_r <= ST_DONE;
            endcase
          end
        end
        ST_VM1: state_r <= ST_VS1;
        ST_VS1: state_r <= ST_VM2;
        ST_VM2: state_r <= ST_VAC;
        ST_VAC: begin
          if (ang_r) av_r[i2] <= sat32(66'(av_r[i2]) + 66'(scaled));
          else lv_r[i2] <= sat32(66'(lv_r[i2]) + 66'(scaled));
          if (i2 != 2'd2) begin
            idx_r   <= idx_r + 4'd1;
            state_r <= ST_VM1;
          end else if (!ang_r && cmd_r == CMD_FORCE_PT) begin
            state_r <= ST_ARM;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_ARM: begin
          idx_r   <= '0;
          state_r <= ST_CMUL;
        end
        ST_CMUL: state_r <= ST_CACC;
        ST_CACC: begin
          if (idx_r == 4'd5) begin
            idx_r   <= '0;
            ang_r   <= 1'b1;
            state_r <= ST_VM1;
          end else begin
            idx_r   <= idx_r + 4'd1;
            state_r <= ST_CMUL;
          end
        end
        ST_PMUL: state_r <= ST_PACC;
        ST_PACC: begin
          pos_r[i2] <= sat32(66'(pos_r[i2]) + 66'(scaled));
          if (i2 != 2'd2) begin
            idx_r   <= idx_r + 4'd1;
            state_r <= ST_PMUL;
          end else begin
            idx_r   <= '0;
            state_r <= (av_r[0] != '0 || av_r[1] != '0 || av_r[2] != '0) ? ST_HMUL : ST_QADD;
          end
        end
        ST_HMUL: state_r <= ST_HACC;
        ST_HACC: begin
          if (i2 != 2'd2) begin
            idx_r   <= idx_r + 4'd1;
            state_r <= ST_HMUL;
          end else begin
            idx_r   <= '0;
            state_r <= ST_QMUL;
          end
        end
        ST_QMUL: state_r <= ST_QACC;
        ST_QACC: begin
          if (idx_r == 4'd11) begin
            idx_r   <= '0;
            state_r <= ST_QADD;
          end else begin
            idx_r   <= idx_r + 4'd1;
            state_r <= ST_QMUL;
          end
        end
        ST_QADD: begin
          // d_r is all zero when the rate step was skipped
          for (int k = 0; k < 4; k++) q_r[k] <= sat32(66'(q_r[k]) + 66'(d_r[k]));
          idx_r   <= '0;
          state_r <= ST_SMUL;
        end
        ST_SMUL: state_r <= ST_SACC;
        ST_SACC: begin
          if (i2 != 2'd3) begin
            idx_r   <= idx_r + 4'd1;
            state_r <= ST_SMUL;
          end else begin
            idx_r   <= '0;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (bit_r == 64'd0) begin
            if (sq_r == 64'd0) begin
              q_r[0]  <= QUAT_ONE;
              q_r[1]  <= '0;
              q_r[2]  <= '0;
              q_r[3]  <= '0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_DSET;
            end
          end
        end
        ST_DSET: begin
          cnt_r   <= '0;
          state_r <= ST_DRUN;
        end
        ST_DRUN: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd32) state_r <= ST_DWB;
        end
        ST_DWB: begin
          if (fric) begin
            if (ang_r) av_r[i2] <= dres;
            else lv_r[i2] <= dres;
            if (i2 != 2'd2) begin
              idx_r   <= idx_r + 4'd1;
              state_r <= ST_DSET;
            end else if (!ang_r) begin
              idx_r   <= '0;
              ang_r   <= 1'b1;
              state_r <= ST_DSET;
            end else begin
              state_r <= ST_DONE;
            end
          end else begin
            q_r[i2] <= dres;
            if (i2 != 2'd3) begin
              idx_r   <= idx_r + 4'd1;
              state_r <= ST_DSET;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_load) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.pos_x  = out_pos_r[0];
  assign out_ch.pos_y  = out_pos_r[1];
  assign out_ch.pos_z  = out_pos_r[2];
  assign out_ch.quat_w = out_q_r[0];
  assign out_ch.quat_x = out_q_r[1];
  assign out_ch.quat_y = out_q_r[2];
  assign out_ch.quat_z = out_q_r[3];

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRUN |-> cnt_r <= 6'd32)
    else $error("divider ran past its quotient width");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("sequencer took an item without leaving idle");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_ch.valid)
    else $error("result load did not raise out valid");

  a_qterm_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QACC || state_r == ST_CACC) |-> idx_r <= 4'd11)
    else $error("term index out of range");

endmodule

>>> tb/tb_rigid_body_integrator_unit.sv
// Self-checking testbench for rigid_body_integrator_unit: random and directed commands, pose checks.
module tb_rigid_body_integrator_unit;
  import rbi_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int QFRAC = 30;

  typedef struct {
    logic [CMD_W-1:0] command;
    scl_t             time_step;
    word_t            vec [3];
    word_t            pnt [3];
    scl_t             friction_coeff;
  } cmd_item_t;

  typedef struct {
    word_t pos [3];
    word_t quat [4];
  } pose_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  scl_t cfg_data;

  rbi_in_if  in_ch ();
  rbi_out_if out_ch ();

  rigid_body_integrator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // body state of the predictor
  longint body_inv_mass;
  longint body_inv_inertia [3];
  longint body_pos [3];
  longint body_vel [3];
  longint body_omega [3];
  longint body_quat [4];

  cmd_item_t pending_cmds [$];
  pose_t     expected_poses [$];
  int        mismatches;
  bit        hold_sender;
  bit        no_idle;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint mul_q(longint a, longint k);
    return clamp32((a * k) >>> FB);
  endfunction

  function automatic longint root64(longint s);
    longint unsigned r;
    longint unsigned b;
    longint unsigned v;
    r = 0;
    v = s;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  task automatic renormalize();
    longint s;
    longint len;
    s = 0;
    for (int i = 0; i < 4; i++) s += (body_quat[i] * body_quat[i]) >>> 2;
    len = root64(s);
    if (len == 0) begin
      body_quat[0] = 64'sd1 << QFRAC;
      for (int i = 1; i < 4; i++) body_quat[i] = 0;
    end else begin
      for (int i = 0; i < 4; i++) body_quat[i] = clamp32((body_quat[i] * (64'sd1 << 29)) / len);
    end
  endtask

  task automatic add_spin(longint dt, longint tq [3]);
    for (int i = 0; i < 3; i++)
      body_omega[i] = clamp32(body_omega[i] + mul_q(mul_q(tq[i], dt), body_inv_inertia[i]));
  endtask

  task automatic integrate_pose(longint dt);
    longint h [3];
    longint d [4];
    longint q [4];
    for (int i = 0; i < 3; i++) body_pos[i] = clamp32(body_pos[i] + mul_q(body_vel[i], dt));
    if (body_omega[0] != 0 || body_omega[1] != 0 || body_omega[2] != 0) begin
      for (int i = 0; i < 3; i++) h[i] = mul_q(body_omega[i], dt);
      q = body_quat;
      d[0] = -((h[0]*q[1]) >>> (FB+1)) - ((h[1]*q[2]) >>> (FB+1)) - ((h[2]*q[3]) >>> (FB+1));
      d[1] = ((h[0]*q[0]) >>> (FB+1)) + ((h[1]*q[3]) >>> (FB+1)) - ((h[2]*q[2]) >>> (FB+1));
      d[2] = ((h[1]*q[0]) >>> (FB+1)) + ((h[2]*q[1]) >>> (FB+1)) - ((h[0]*q[3]) >>> (FB+1));
      d[3] = ((h[2]*q[0]) >>> (FB+1)) + ((h[0]*q[2]) >>> (FB+1)) - ((h[1]*q[1]) >>> (FB+1));
      for (int i = 0; i < 4; i++) body_quat[i] = clamp32(body_quat[i] + d[i]);
    end
    renormalize();
  endtask

  task automatic predict_pose(cmd_item_t it);
    longint dt;
    longint den;
    longint v [3];
    longint p [3];
    longint arm [3];
    longint tq [3];
    pose_t r;
    dt = longint'(it.time_step);
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'(it.vec[i]);
      p[i] = longint'(it.pnt[i]);
    end
    case (it.command)
      CMD_FORCE, CMD_FORCE_PT: begin
        for (int i = 0; i < 3; i++)
          body_vel[i] = clamp32(body_vel[i] + mul_q(mul_q(v[i], dt), body_inv_mass));
        if (it.command == CMD_FORCE_PT) begin
          for (int i = 0; i < 3; i++) arm[i] = clamp32(p[i] - body_pos[i]);
          tq[0] = clamp32(((arm[1]*v[2]) >>> FB) - ((arm[2]*v[1]) >>> FB));
          tq[1] = clamp32(((arm[2]*v[0]) >>> FB) - ((arm[0]*v[2]) >>> FB));
          tq[2] = clamp32(((arm[0]*v[1]) >>> FB) - ((arm[1]*v[0]) >>> FB));
          add_spin(dt, tq);
        end
      end
      CMD_TORQUE: add_spin(dt, v);
      CMD_FRICTION: begin
        den = (64'sd1 << FB) + longint'(it.friction_coeff);
        for (int i = 0; i < 3; i++) begin
          body_vel[i] = (body_vel[i] * (64'sd1 << FB)) / den;
          body_omega[i] = (body_omega[i] * (64'sd1 << FB)) / den;
        end
      end
      CMD_UPDATE: integrate_pose(dt);
      default: ;
    endcase
    for (int i = 0; i < 3; i++) r.pos[i] = word_t'(body_pos[i]);
    for (int i = 0; i < 4; i++) r.quat[i] = word_t'(body_quat[i]);
    expected_poses.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid          <= 1'b0;
      in_ch.command        <= CMD_FORCE;
      in_ch.time_step      <= '0;
      in_ch.vec_x          <= '0;
      in_ch.vec_y          <= '0;
      in_ch.vec_z          <= '0;
      in_ch.point_x        <= '0;
      in_ch.point_y        <= '0;
      in_ch.point_z        <= '0;
      in_ch.friction_coeff <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_pose(pending_cmds.pop_front());
      if (pending_cmds.size() > 0 && !hold_sender &&
          (no_idle || $urandom_range(99) >= 29)) begin
        in_ch.valid          <= 1'b1;
        in_ch.command        <= pending_cmds[0].command;
        in_ch.time_step      <= pending_cmds[0].time_step;
        in_ch.vec_x          <= pending_cmds[0].vec[0];
        in_ch.vec_y          <= pending_cmds[0].vec[1];
        in_ch.vec_z          <= pending_cmds[0].vec[2];
        in_ch.point_x        <= pending_cmds[0].pnt[0];
        in_ch.point_y        <= pending_cmds[0].pnt[1];
        in_ch.point_z        <= pending_cmds[0].pnt[2];
        in_ch.friction_coeff <= pending_cmds[0].friction_coeff;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pose item pos_x=%0d", out_ch.pos_x);
        end else begin
          e = expected_poses.pop_front();
          if (out_ch.pos_x !== e.pos[0] || out_ch.pos_y !== e.pos[1] ||
              out_ch.pos_z !== e.pos[2] || out_ch.quat_w !== e.quat[0] ||
              out_ch.quat_x !== e.quat[1] || out_ch.quat_y !== e.quat[2] ||
              out_ch.quat_z !== e.quat[3]) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"pose mismatch: exp pos %0d %0d %0d q %0d %0d %0d %0d,",
                        " got pos %0d %0d %0d q %0d %0d %0d %0d"},
                       e.pos[0], e.pos[1], e.pos[2], e.quat[0], e.quat[1], e.quat[2], e.quat[3],
                       out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
                       out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z);
          end
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return word_t'($urandom);
      default: return word_t'($signed($urandom_range(8 << FB)) - (4 << FB));
    endcase
  endfunction

  function automatic scl_t rand_scalar();
    case ($urandom_range(7))
      0: return scl_t'('1);
      1: return '0;
      2: return scl_t'($urandom);
      default: return scl_t'($urandom_range(1 << FB));
    endcase
  endfunction

  function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] c, scl_t dt, word_t vx, word_t vy,
                                        word_t vz, word_t px, word_t py, word_t pz, scl_t fc);
    cmd_item_t it;
    it.command = c;
    it.time_step = dt;
    it.vec[0] = vx; it.vec[1] = vy; it.vec[2] = vz;
    it.pnt[0] = px; it.pnt[1] = py; it.pnt[2] = pz;
    it.friction_coeff = fc;
    return it;
  endfunction

  function automatic cmd_item_t rand_cmd();
    logic [CMD_W-1:0] c;
    int r;
    r = $urandom_range(99);
    if (r < 20) c = CMD_FORCE;
    else if (r < 40) c = CMD_FORCE_PT;
    else if (r < 58) c = CMD_TORQUE;
    else if (r < 68) c = CMD_FRICTION;
    else if (r < 96) c = CMD_UPDATE;
    else c = CMD_W'($urandom_range(7));
    return make_cmd(c, rand_scalar(), rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_word(), rand_word(), rand_scalar());
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || in_ch.valid || expected_poses.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, scl_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_INV_MASS) body_inv_mass = longint'(val);
    else body_inv_inertia[idx - 1] = longint'(val);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_cmds.push_back(rand_cmd());
  endtask

  initial begin
    mismatches = 0;
    hold_sender = 1'b0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_INV_MASS;
    cfg_data = '0;
    body_inv_mass = 64'sd1 << FB;
    for (int i = 0; i < 3; i++) begin
      body_inv_inertia[i] = 64'sd1 << FB;
      body_pos[i] = 0; body_vel[i] = 0; body_omega[i] = 0;
    end
    body_quat[0] = 64'sd1 << QFRAC;
    for (int i = 1; i < 4; i++) body_quat[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pending_cmds.push_back(make_cmd(CMD_UPDATE, scl_t'(1 << FB), 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FORCE, scl_t'(1 << FB), 1 << FB, -(2 << FB), 3 << FB,
                                    0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_UPDATE, scl_t'(1 << (FB - 2)), 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FORCE_PT, scl_t'(1 << (FB - 4)), 1 << FB, 2 << FB,
                                    -(1 << FB), 3 << FB, -(1 << FB), 2 << FB, 0));
    pending_cmds.push_back(make_cmd(CMD_TORQUE, scl_t'(1 << (FB - 3)), 1 << FB, 0, -(1 << FB),
                                    0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_UPDATE, scl_t'(1 << (FB - 3)), 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FRICTION, 0, 0, 0, 0, 0, 0, 0, scl_t'(1 << FB)));
    pending_cmds.push_back(make_cmd(CMD_FRICTION, 0, 0, 0, 0, 0, 0, 0, scl_t'('1)));
    pending_cmds.push_back(make_cmd(CMD_FORCE, scl_t'('1), 32'sh7FFF_FFFF, 32'sh8000_0000,
                                    32'sh7FFF_FFFF, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_FORCE_PT, scl_t'('1), 32'sh8000_0000, 32'sh7FFF_FFFF,
                                    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                    32'sh7FFF_FFFF, scl_t'('1)));
    pending_cmds.push_back(make_cmd(CMD_UPDATE, scl_t'('1), 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_TORQUE, scl_t'('1), 32'sh8000_0000, 32'sh8000_0000,
                                    32'sh8000_0000, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_UPDATE, scl_t'('1), 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(3'd5, 1, 1, 1, 1, 1, 1, 1, 1));
    pending_cmds.push_back(make_cmd(3'd7, 0, -1, -1, -1, -1, -1, -1, 0));
    pending_cmds.push_back(make_cmd(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    write_reg(CFG_INV_MASS, '0);
    write_reg(CFG_INV_IX, scl_t'('1));
    write_reg(CFG_INV_IY, '0);
    write_reg(CFG_INV_IZ, scl_t'(1 << (FB + 2)));
    run_random(150);
    drain();

    write_reg(CFG_INV_MASS, scl_t'('1));
    write_reg(CFG_INV_IX, scl_t'(1 << (FB - 3)));
    write_reg(CFG_INV_IY, scl_t'(1 << FB));
    write_reg(CFG_INV_IZ, scl_t'('1));
    no_idle = 1'b1;
    run_random(200);
    drain();
    no_idle = 1'b0;

    write_reg(CFG_INV_MASS, scl_t'(1 << FB));
    write_reg(CFG_INV_IX, scl_t'(1 << FB));
    write_reg(CFG_INV_IY, scl_t'(1 << (FB - 1)));
    write_reg(CFG_INV_IZ, scl_t'(1 << FB));
    run_random(275);
    while (pending_cmds.size() > 137) @(posedge clk);
    hold_sender = 1'b1;
    while (in_ch.valid || expected_poses.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    run_random(275);
    drain();

    if (mismatches == 0) $display("rigid_body_integrator_unit regression: pass");
    else $display("rigid_body_integrator_unit regression: fail");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("rigid_body_integrator_unit regression: fail");
    $finish;
  end

endmodule

>>> rigid_body_integrator_unit.f
rtl/rbi_pkg.sv
rtl/rbi_chan_if.sv
rtl/rigid_body_integrator_unit.sv
tb/tb_rigid_body_integrator_unit.sv
